[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands; empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(lbl, clk, rst, cond, conseq) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst, cond, conseq) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rst, cond, conseq)
`define ASSERT_NEXT(lbl, clk, rst, cond, conseq)

`endif

`endif

[design/id3fx_pkg.sv]
// ----------------------------------------------------------------------------
// id3fx_pkg
// Types and constants of the tag frame extractor
// ----------------------------------------------------------------------------
`default_nettype none

package id3fx_pkg;

   // parser phase
   typedef enum logic [2:0] {
      PH_SIG     = 3'd0,
      PH_HDR     = 3'd1,
      PH_FID     = 3'd2,
      PH_FSIZE   = 3'd3,
      PH_FLAGS   = 3'd4,
      PH_ENC     = 3'd5,
      PH_PAYLOAD = 3'd6,
      PH_SKIP    = 3'd7
   } phase_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_BYTE     = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_BADSIG   = 3'd3,
      ST_TRUNC    = 3'd4
   } status_type;

   // tag signature "ID3"
   localparam logic [7:0] SIG_CHAR0 = 8'h49;
   localparam logic [7:0] SIG_CHAR1 = 8'h44;
   localparam logic [7:0] SIG_CHAR2 = 8'h33;
   localparam logic [31:0] SIG_BYTES = 32'd3;

   // frame header field lengths
   localparam logic [31:0] FID_BYTES  = 32'd4;
   localparam logic [31:0] SIZE_BYTES = 32'd4;

   // reset value of the target frame id ("TIT2")
   localparam logic [31:0] TARGET_RESET = 32'h5449_5432;

endpackage

`default_nettype wire

[design/id3_frame_extractor.sv]
// ----------------------------------------------------------------------------
// id3_frame_extractor
// Walks a tagged file byte by byte and returns the payload of one text frame
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one file byte per transfer, with start and end of file marks.
//            A start mark restarts the search; before the first start after
//            reset, and after a search has finished, bytes are dropped.
//   rsp_*  : payload bytes of the target frame (text encoding byte removed),
//            or a single status result; rsp_last marks the search's final
//            result.
//   csr_*  : writes the four-character frame id sought; always ready.
//            Reset value is "TIT2".
//   Output : a result appears on rsp_* the cycle after the byte that causes
//            it is transferred in. Rate: one byte per cycle while no byte is
//            stalled; the parser step is a counter, a shift and a 32-bit compare.
//   When rsp_stall holds a result in the output register, bytes that cause
//   no result are still taken; a byte that would cause one is stalled until
//   the output register drains.
//   Reset (synchronous, active high) empties the output register and puts
//   the parser in its idle state waiting for a start mark.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module id3_frame_extractor #(
   parameter int HEADER_BYTES = 10,
   parameter int FLAG_BYTES   = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input byte channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_of_file,
   input  wire logic        req_end_of_file,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_last,
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_target_frame_id
);

   localparam logic [31:0] HDR_LEN  = 32'(HEADER_BYTES);
   localparam logic [31:0] FLAG_LEN = 32'(FLAG_BYTES);

   // parser state
   id3fx_pkg::phase_type phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] size_ff, size_in;
   logic        done_ff, done_in;
   logic [31:0] target_ff;

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [7:0]  rsp_byte_ff;
   logic        rsp_last_ff;

   // state as seen by this byte (start mark restarts)
   id3fx_pkg::phase_type eff_phase;
   logic [31:0] eff_count;
   logic [31:0] eff_id;
   logic [31:0] eff_size;
   logic        eff_done;

   logic [31:0] count_inc;
   logic [31:0] count_dec;
   logic [31:0] id_shift;
   logic [31:0] size_shift;
   logic [31:0] hd_size;
   logic [7:0]  sig_want;

   logic                  fin;
   id3fx_pkg::status_type fin_code;

   logic                  res_valid;
   id3fx_pkg::status_type res_status;
   logic [7:0]            res_byte;
   logic                  res_last;

   logic req_xfer;
   logic rsp_xfer;

   // restart on start of file
   assign eff_phase = req_start_of_file ? id3fx_pkg::PH_SIG : phase_ff;
   assign eff_count = req_start_of_file ? 32'd0 : count_ff;
   assign eff_id    = req_start_of_file ? 32'd0 : id_ff;
   assign eff_size  = req_start_of_file ? 32'd0 : size_ff;
   assign eff_done  = req_start_of_file ? 1'b0  : done_ff;

   // shared datapath pieces
   assign count_inc  = eff_count + 32'd1;
   assign count_dec  = (eff_count != 32'd0) ? eff_count - 32'd1 : eff_count;
   assign id_shift   = {eff_id[23:0], req_data_byte};
   assign size_shift = {eff_size[23:0], req_data_byte};
   assign hd_size    = (eff_phase == id3fx_pkg::PH_FSIZE) ? size_shift : eff_size;
   assign sig_want   = (eff_count == 32'd0) ? id3fx_pkg::SIG_CHAR0 :
                       (eff_count == 32'd1) ? id3fx_pkg::SIG_CHAR1 :
                                              id3fx_pkg::SIG_CHAR2;

   // next state of the parser
   always_comb begin
      phase_in = eff_phase;
      count_in = eff_count;
      id_in    = eff_id;
      size_in  = eff_size;
      done_in  = eff_done;
      fin      = 1'b0;
      fin_code = id3fx_pkg::ST_NOTFOUND;
      if (!eff_done) begin
         unique case (eff_phase) inside
            id3fx_pkg::PH_SIG: begin
               if (req_data_byte != sig_want) begin
                  fin      = 1'b1;
                  fin_code = id3fx_pkg::ST_BADSIG;
               end else begin
                  count_in = count_inc;
                  if (count_inc >= id3fx_pkg::SIG_BYTES) begin
                     if (count_inc >= HDR_LEN) begin
                        phase_in = id3fx_pkg::PH_FID;
                        count_in = 32'd0;
                     end else begin
                        phase_in = id3fx_pkg::PH_HDR;
                     end
                  end
               end
            end
            id3fx_pkg::PH_HDR: begin
               count_in = count_inc;
               if (count_inc >= HDR_LEN) begin
                  phase_in = id3fx_pkg::PH_FID;
                  count_in = 32'd0;
               end
            end
            id3fx_pkg::PH_FID: begin
               id_in    = id_shift;
               count_in = count_inc;
               if (count_inc >= id3fx_pkg::FID_BYTES) begin
                  count_in = 32'd0;
                  if (id_shift == 32'd0) begin
                     fin      = 1'b1;
                     fin_code = id3fx_pkg::ST_NOTFOUND;
                  end else begin
                     phase_in = id3fx_pkg::PH_FSIZE;
                  end
               end
            end
            id3fx_pkg::PH_FSIZE,
            id3fx_pkg::PH_FLAGS: begin
               if (eff_phase == id3fx_pkg::PH_FSIZE) begin
                  size_in = size_shift;
               end
               count_in = count_inc;
               if ((eff_phase == id3fx_pkg::PH_FSIZE &&
                    count_inc >= id3fx_pkg::SIZE_BYTES && FLAG_LEN == 32'd0) ||
                   (eff_phase == id3fx_pkg::PH_FLAGS && count_inc >= FLAG_LEN)) begin
                  // frame header complete: match, skip or move on
                  count_in = 32'd0;
                  if (eff_id == target_ff) begin
                     if (hd_size == 32'd0) begin
                        fin      = 1'b1;
                        fin_code = id3fx_pkg::ST_EMPTY;
                     end else begin
                        phase_in = id3fx_pkg::PH_ENC;
                     end
                  end else if (hd_size == 32'd0) begin
                     phase_in = id3fx_pkg::PH_FID;
                  end else begin
                     phase_in = id3fx_pkg::PH_SKIP;
                     count_in = hd_size;
                  end
               end else if (eff_phase == id3fx_pkg::PH_FSIZE &&
                            count_inc >= id3fx_pkg::SIZE_BYTES) begin
                  count_in = 32'd0;
                  phase_in = id3fx_pkg::PH_FLAGS;
               end
            end
            id3fx_pkg::PH_ENC: begin
               if (eff_size <= 32'd1) begin
                  fin      = 1'b1;
                  fin_code = id3fx_pkg::ST_EMPTY;
               end else begin
                  phase_in = id3fx_pkg::PH_PAYLOAD;
                  count_in = eff_size - 32'd1;
               end
            end
            id3fx_pkg::PH_PAYLOAD: begin
               count_in = count_dec;
               if (count_dec == 32'd0) begin
                  done_in = 1'b1;
               end
            end
            id3fx_pkg::PH_SKIP: begin
               count_in = count_dec;
               if (count_dec == 32'd0) begin
                  phase_in = id3fx_pkg::PH_FID;
               end
            end
            default: begin
               phase_in = eff_phase;
            end
         endcase
         // end of file before the search is over
         if (req_end_of_file && !done_in && !fin) begin
            fin = 1'b1;
            if (phase_in == id3fx_pkg::PH_SIG) begin
               fin_code = id3fx_pkg::ST_BADSIG;
            end else if (phase_in == id3fx_pkg::PH_ENC ||
                         phase_in == id3fx_pkg::PH_PAYLOAD) begin
               fin_code = id3fx_pkg::ST_TRUNC;
            end else begin
               fin_code = id3fx_pkg::ST_NOTFOUND;
            end
         end
         if (fin) begin
            done_in = 1'b1;
         end
      end
   end

   // result of this byte
   always_comb begin
      res_valid  = !eff_done && (fin || eff_phase == id3fx_pkg::PH_PAYLOAD);
      res_status = fin ? fin_code : id3fx_pkg::ST_BYTE;
      res_byte   = fin ? 8'd0 : req_data_byte;
      res_last   = fin || done_in;
   end

   // handshakes: stall only a byte that needs the held output register
   assign req_stall = rsp_valid_ff && rsp_stall && res_valid;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= id3fx_pkg::PH_SIG;
         count_ff <= 32'd0;
         id_ff    <= 32'd0;
         size_ff  <= 32'd0;
         done_ff  <= 1'b1;
      end else if (req_xfer) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         id_ff    <= id_in;
         size_ff  <= size_in;
         done_ff  <= done_in;
      end
   end

   // target frame id register
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= id3fx_pkg::TARGET_RESET;
      end else if (csr_valid && csr_ready) begin
         target_ff <= csr_target_frame_id;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer && res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer && res_valid) begin
         rsp_status_ff <= res_status;
         rsp_byte_ff   <= res_byte;
         rsp_last_ff   <= res_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_last         = rsp_last_ff;

   // checks
   `ASSERT_SAME(a_stall_needs_full, clock, reset, req_stall, rsp_valid_ff)
   `ASSERT_NEXT(a_last_ends_search, clock, reset,
                req_xfer && res_valid && res_last, done_ff)
   `ASSERT_SAME(a_status_is_last, clock, reset,
                rsp_valid_ff && rsp_status_ff != id3fx_pkg::ST_BYTE,
                rsp_last_ff && rsp_byte_ff == 8'd0)
   `ASSERT_SAME(a_count_live, clock, reset,
                !done_ff && (phase_ff == id3fx_pkg::PH_PAYLOAD ||
                             phase_ff == id3fx_pkg::PH_SKIP),
                count_ff != 32'd0)

endmodule

`default_nettype wire

[sim/tb_id3_frame_extractor.sv]
// ----------------------------------------------------------------------------
// tb_id3_frame_extractor
// Self-checking bench for the tag frame extractor: a short table of
// hand-picked bytes, then random tagged files and noise, under several
// target frame ids, with random sender gaps and receiver stalls. Each
// result is checked against a table row or a cycle-free model of the frame walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_id3_frame_extractor;

   localparam int unsigned HDR_LEN     = 10;
   localparam int unsigned FLAG_LEN    = 2;
   localparam int          PHASE_ITEMS = 215;
   localparam int          DIR_ROWS    = 26;

   typedef struct packed {
      id3fx_pkg::status_type status;
      logic [7:0]            payload;
      logic                  last;
   } tag_result_type;

   // how a table row gets its expectation
   typedef enum logic [1:0] {
      CHK_MODEL  = 2'd0,
      CHK_NONE   = 2'd1,
      CHK_RESULT = 2'd2
   } check_kind_type;

   typedef struct {
      logic [7:0]      data;
      logic            sof;
      logic            eof;
      check_kind_type  kind;
      tag_result_type  res;
   } stim_row_type;

   localparam tag_result_type NO_RES       = '{id3fx_pkg::ST_BYTE, 8'h00, 1'b0};
   localparam tag_result_type BADSIG_RES   = '{id3fx_pkg::ST_BADSIG, 8'h00, 1'b1};
   localparam tag_result_type NOTFOUND_RES = '{id3fx_pkg::ST_NOTFOUND, 8'h00, 1'b1};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_start_of_file = 1'b0;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_target_frame_id = 32'h0000_0000;

   id3_frame_extractor #(
      .HEADER_BYTES (HDR_LEN),
      .FLAG_BYTES   (FLAG_LEN)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_data_byte       (req_data_byte),
      .req_start_of_file   (req_start_of_file),
      .req_end_of_file     (req_end_of_file),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_payload_byte    (rsp_payload_byte),
      .rsp_last            (rsp_last),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_target_frame_id (csr_target_frame_id)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // parser model state
   logic [31:0]          target_id = id3fx_pkg::TARGET_RESET;
   id3fx_pkg::phase_type prs_phase = id3fx_pkg::PH_SIG;
   logic [31:0]          prs_count = '0;
   logic [31:0]          prs_id = '0;
   logic [31:0]          prs_size = '0;
   bit                   prs_done = 1'b1;
   bit                   step_has_result;
   tag_result_type       step_result;

   tag_result_type tag_expect_q[$];
   logic [7:0]     file_bytes[$];
   bit             file_has_eof;
   int             sent_items = 0;
   int             burst_left = 0;
   int             fail_count = 0;

   task automatic mismatch_report(input string msg);
      fail_count++;
      $display("%0t mismatch: %s", $realtime, msg);
   endtask

   // final result of a search, parser then idles until a start mark
   function automatic void close_search(input id3fx_pkg::status_type st);
      step_has_result = 1'b1;
      step_result = '{st, 8'h00, 1'b1};
      prs_done = 1'b1;
   endfunction

   // frame id, size and flags all in: match, skip or next frame
   function automatic void frame_header_end();
      prs_count = '0;
      if (prs_id == target_id) begin
         if (prs_size == 0)
            close_search(id3fx_pkg::ST_EMPTY);
         else
            prs_phase = id3fx_pkg::PH_ENC;
      end else if (prs_size == 0) begin
         prs_phase = id3fx_pkg::PH_FID;
      end else begin
         prs_phase = id3fx_pkg::PH_SKIP;
         prs_count = prs_size;
      end
   endfunction

   // one file byte through the model; returns 0 when the byte is ignored
   function automatic bit parse_tag_byte(input logic [7:0] b, input logic sof,
                                         input logic eof);
      logic [7:0] want;
      step_has_result = 1'b0;
      step_result = NO_RES;
      if (sof) begin
         prs_phase = id3fx_pkg::PH_SIG;
         prs_count = '0;
         prs_id = '0;
         prs_size = '0;
         prs_done = 1'b0;
      end
      if (prs_done)
         return 1'b0;
      case (prs_phase)
         id3fx_pkg::PH_SIG: begin
            want = (prs_count == 0) ? id3fx_pkg::SIG_CHAR0 :
                   (prs_count == 1) ? id3fx_pkg::SIG_CHAR1 : id3fx_pkg::SIG_CHAR2;
            if (b != want) begin
               close_search(id3fx_pkg::ST_BADSIG);
            end else begin
               prs_count++;
               if (prs_count >= id3fx_pkg::SIG_BYTES) begin
                  if (prs_count >= HDR_LEN) begin
                     prs_phase = id3fx_pkg::PH_FID;
                     prs_count = '0;
                  end else begin
                     prs_phase = id3fx_pkg::PH_HDR;
                  end
               end
            end
         end
         id3fx_pkg::PH_HDR: begin
            prs_count++;
            if (prs_count >= HDR_LEN) begin
               prs_phase = id3fx_pkg::PH_FID;
               prs_count = '0;
            end
         end
         id3fx_pkg::PH_FID: begin
            prs_id = {prs_id[23:0], b};
            prs_count++;
            if (prs_count >= id3fx_pkg::FID_BYTES) begin
               prs_count = '0;
               if (prs_id == 0)
                  close_search(id3fx_pkg::ST_NOTFOUND);
               else
                  prs_phase = id3fx_pkg::PH_FSIZE;
            end
         end
         id3fx_pkg::PH_FSIZE: begin
            prs_size = {prs_size[23:0], b};
            prs_count++;
            if (prs_count >= id3fx_pkg::SIZE_BYTES) begin
               prs_count = '0;
               if (FLAG_LEN == 0)
                  frame_header_end();
               else
                  prs_phase = id3fx_pkg::PH_FLAGS;
            end
         end
         id3fx_pkg::PH_FLAGS: begin
            prs_count++;
            if (prs_count >= FLAG_LEN)
               frame_header_end();
         end
         id3fx_pkg::PH_ENC: begin
            // text encoding byte is dropped
            if (prs_size <= 1) begin
               close_search(id3fx_pkg::ST_EMPTY);
            end else begin
               prs_phase = id3fx_pkg::PH_PAYLOAD;
               prs_count = prs_size - 1;
            end
         end
         id3fx_pkg::PH_PAYLOAD: begin
            step_has_result = 1'b1;
            step_result = '{id3fx_pkg::ST_BYTE, b, 1'b0};
            if (prs_count > 0)
               prs_count--;
            if (prs_count == 0) begin
               step_result.last = 1'b1;
               prs_done = 1'b1;
            end
         end
         default: begin
            if (prs_count > 0)
               prs_count--;
            if (prs_count == 0)
               prs_phase = id3fx_pkg::PH_FID;
         end
      endcase
      // end of file while the search is still open
      if (eof && !prs_done) begin
         if (prs_phase == id3fx_pkg::PH_SIG)
            close_search(id3fx_pkg::ST_BADSIG);
         else if (prs_phase == id3fx_pkg::PH_ENC || prs_phase == id3fx_pkg::PH_PAYLOAD)
            close_search(id3fx_pkg::ST_TRUNC);
         else
            close_search(id3fx_pkg::ST_NOTFOUND);
      end
      return 1'b1;
   endfunction

   // one byte transfer, with sender bursts and gaps
   task automatic push_byte(input logic [7:0] b, input logic sof, input logic eof,
                            input check_kind_type kind = CHK_MODEL,
                            input tag_result_type typed = NO_RES);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_start_of_file <= sof;
      req_end_of_file <= eof;
      do @(posedge clock); while (req_stall);
      void'(parse_tag_byte(b, sof, eof));
      sent_items++;
      if (kind == CHK_RESULT)
         tag_expect_q.push_back(typed);
      else if (kind == CHK_MODEL && step_has_result)
         tag_expect_q.push_back(step_result);
   endtask

   // hold off the sender until every expected result is back
   task automatic wait_drained(input int tail);
      req_valid <= 1'b0;
      while (tag_expect_q.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic program_target(input logic [31:0] fid);
      csr_valid <= 1'b1;
      csr_target_frame_id <= fid;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      target_id = fid;
   endtask

   // random tag file, mostly well formed
   function automatic void build_tag_file();
      logic [31:0] fid;
      logic [31:0] fsize;
      int          cut;
      file_bytes.delete();
      file_has_eof = ($urandom_range(0, 7) != 0);
      file_bytes.push_back(id3fx_pkg::SIG_CHAR0);
      file_bytes.push_back(id3fx_pkg::SIG_CHAR1);
      file_bytes.push_back(id3fx_pkg::SIG_CHAR2);
      if ($urandom_range(0, 9) == 0)
         file_bytes[$urandom_range(0, 2)] = 8'($urandom);
      repeat (HDR_LEN - 3) file_bytes.push_back(8'($urandom));
      for (int f = $urandom_range(0, 4); f > 0; f--) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: fid = target_id;
            4:          fid = target_id ^ (32'h1 << $urandom_range(0, 31));
            5:          fid = 32'h5441_4C42;
            6:          fid = id3fx_pkg::TARGET_RESET;
            7:          fid = 32'hFFFF_FFFF;
            8:          fid = {8'h00, 24'($urandom)};
            default:    fid = $urandom;
         endcase
         case ($urandom_range(0, 15))
            0:       fsize = 32'd0;
            1:       fsize = 32'd1;
            2:       fsize = 32'd2;
            14:      fsize = {8'($urandom_range(1, 255)), 24'($urandom)};
            15:      fsize = 32'hFFFF_FFFF;
            default: fsize = $urandom_range(3, 12);
         endcase
         for (int k = 3; k >= 0; k--) file_bytes.push_back(fid[8*k +: 8]);
         for (int k = 3; k >= 0; k--) file_bytes.push_back(fsize[8*k +: 8]);
         repeat (FLAG_LEN) file_bytes.push_back(8'($urandom));
         // oversized frame: the file ends inside it
         if (fsize > 32) begin
            repeat ($urandom_range(0, 12)) file_bytes.push_back(8'($urandom));
            file_has_eof = 1'b1;
            return;
         end
         repeat (fsize) file_bytes.push_back(8'($urandom));
      end
      // padding after the last frame
      if ($urandom_range(0, 2) == 0) begin
         repeat (4) file_bytes.push_back(8'h00);
         repeat ($urandom_range(0, 6)) file_bytes.push_back(8'($urandom));
      end
      // cut short somewhere
      if ($urandom_range(0, 4) == 0) begin
         cut = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
   endfunction

   // result channel checks
   always @(posedge clock) begin
      tag_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tag_expect_q.size() == 0) begin
            mismatch_report($sformatf("result with none expected, status %0d", rsp_status));
         end else begin
            exp_res = tag_expect_q.pop_front();
            if (rsp_status !== exp_res.status)
               mismatch_report($sformatf("status %0d, expected %0d",
                                         rsp_status, exp_res.status));
            if (rsp_payload_byte !== exp_res.payload)
               mismatch_report($sformatf("payload_byte %h, expected %h",
                                         rsp_payload_byte, exp_res.payload));
            if (rsp_last !== exp_res.last)
               mismatch_report($sformatf("last %b, expected %b", rsp_last, exp_res.last));
         end
      end
   end

   // receiver stalls, switching between patterns
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_left[2];
      endcase
   end

   initial begin
      #2_000_000;
      $display("[id3_frame_extractor] ERROR");
      $finish;
   end

   initial begin
      stim_row_type directed_rows [DIR_ROWS];
      logic [31:0]  phase_targets [5];
      int           phase_start;
      int           n;

      directed_rows = '{
         '{8'hA5, 1'b0, 1'b1, CHK_NONE,   NO_RES},       // idle before any start
         '{8'h00, 1'b1, 1'b0, CHK_RESULT, BADSIG_RES},   // wrong first char
         '{8'h49, 1'b1, 1'b1, CHK_RESULT, BADSIG_RES},   // end inside signature
         '{8'h49, 1'b1, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h44, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'hFF, 1'b0, 1'b0, CHK_RESULT, BADSIG_RES},   // wrong third char
         '{8'h49, 1'b1, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h44, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h49, 1'b1, 1'b0, CHK_MODEL,  NO_RES},       // restart mid signature
         '{8'h44, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h33, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'hFF, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h00, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h80, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h7F, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h01, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'hFE, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h00, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h00, 1'b0, 1'b0, CHK_MODEL,  NO_RES},       // all-zero frame id
         '{8'h00, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h00, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h00, 1'b0, 1'b0, CHK_RESULT, NOTFOUND_RES},
         '{8'h33, 1'b0, 1'b1, CHK_NONE,   NO_RES},       // end mark after search done
         '{8'h49, 1'b1, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h44, 1'b0, 1'b0, CHK_MODEL,  NO_RES},
         '{8'h33, 1'b0, 1'b1, CHK_RESULT, NOTFOUND_RES}  // end inside tag header
      };
      phase_targets = '{id3fx_pkg::TARGET_RESET, 32'h0000_0000, 32'hFFFF_FFFF,
                        {8'($urandom_range(65, 90)), 8'($urandom_range(65, 90)),
                         8'($urandom_range(65, 90)), 8'($urandom_range(48, 57))},
                        $urandom};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table, target left at its reset value
      foreach (directed_rows[i])
         push_byte(directed_rows[i].data, directed_rows[i].sof, directed_rows[i].eof,
                   directed_rows[i].kind, directed_rows[i].res);

      // random phases, one target id each
      foreach (phase_targets[p]) begin
         wait_drained(4);
         program_target(phase_targets[p]);
         phase_start = sent_items;
         while (sent_items - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 7) == 0) begin
               // noise: random bytes and marks
               n = $urandom_range(1, 16);
               for (int i = 0; i < n; i++)
                  push_byte(8'($urandom),
                            (i == 0) ? ($urandom_range(0, 3) != 0)
                                     : ($urandom_range(0, 15) == 0),
                            $urandom_range(0, 4) == 0);
            end else begin
               build_tag_file();
               foreach (file_bytes[i])
                  push_byte(file_bytes[i], i == 0,
                            file_has_eof && (i == file_bytes.size() - 1));
            end
         end
      end

      wait_drained(8);
      if (fail_count == 0)
         $display("[id3_frame_extractor] OK");
      else
         $display("[id3_frame_extractor] ERROR");
      $finish;
   end

endmodule
